// ===== rtl/runlist_vcn_to_sector_defines.svh =====
// Assertion macros used by the runlist decoder checker.
`ifndef RUNLIST_VCN_TO_SECTOR_DEFINES_SVH
`define RUNLIST_VCN_TO_SECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RVTS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RVTS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rvts_pkg.sv =====
// Types and constants shared by the runlist decoder modules.
package rvts_pkg;

	// Parser phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_LENGTH,
		PH_OFFSET,
		PH_DONE
	} phase_t;

	// Input action codes
	localparam logic ACT_BEGIN = 1'b0;
	localparam logic ACT_BYTE  = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_END       = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	// Largest legal field size in bytes
	localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

	// Register map: word index bit of paddr
	localparam logic REG_SPC = 1'b0;
	localparam logic [7:0] SPC_RESET = 8'd8;

	// Finished-run record handed from the parser to the mapping stages
	typedef struct packed {
		logic        emit;
		logic [1:0]  status;
		logic [63:0] into;
		logic [63:0] run_len;
		logic [63:0] lcn_base;
		logic [31:0] wanted;
	} run_hit_t;

endpackage

// ===== rtl/runlist_vcn_to_sector.sv =====
// A run's last byte is captured, then passes the stage 2, 3 and output registers.
// Throughput: one item per cycle unless stalled; the VCN/LCN update is combinational.
// Stages: input register, parse step, LCN sum and clamp, sector multiply (output register).
// Reset clears the pipeline and the lookup (parser idle until a begin item);
// the cluster size register resets to 8 sectors.
module runlist_vcn_to_sector
	import rvts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input item
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        action,
	input  logic [63:0] target_vcn,
	input  logic [31:0] cluster_count,
	input  logic [7:0]  runlist_byte,
	// result item
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [63:0] start_sector,
	output logic [38:0] sector_count,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]  spc_q;

	logic        valid_s1;
	logic        action_s1;
	logic [63:0] target_s1;
	logic [31:0] count_s1;
	logic [7:0]  byte_s1;

	logic        valid_s2;
	run_hit_t    hit_s2;

	logic        valid_s3;
	logic [1:0]  status_s3;
	logic [63:0] lcn_s3;
	logic [31:0] clusters_s3;

	logic        valid_s4;
	logic [1:0]  status_s4;
	logic [63:0] start_s4;
	logic [38:0] count_s4;

	logic        s2_free;
	logic        s3_free;
	logic        s4_free;
	logic        step;
	run_hit_t    hit;
	logic [63:0] remaining;
	logic [31:0] clusters;
	logic [71:0] start_prod;
	logic [39:0] count_prod;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SPC) ? {24'd0, spc_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q <= SPC_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SPC) begin
			spc_q <= pwdata[7:0];
		end
	end

	// Stall chain from the output back to the input
	assign s4_free    = !valid_s4 || result_ready;
	assign s3_free    = !valid_s3 || s4_free;
	assign s2_free    = !valid_s2 || s3_free;
	assign item_ready = !valid_s1 || s2_free;
	assign step       = valid_s1 && s2_free;

	// Stage 1: capture the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			action_s1 <= action;
			target_s1 <= target_vcn;
			count_s1  <= cluster_count;
			byte_s1   <= runlist_byte;
		end
	end

	// Stage 2: parse step
	rvts_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.action        (action_s1),
		.target_vcn    (target_s1),
		.cluster_count (count_s1),
		.runlist_byte  (byte_s1),
		.hit           (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= step && hit.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			hit_s2 <= hit;
		end
	end

	// Stage 3: absolute LCN and clamp to run end
	always_comb begin
		remaining = hit_s2.run_len - hit_s2.into;
		clusters  = ({32'd0, hit_s2.wanted} < remaining) ? hit_s2.wanted : remaining[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free) begin
			status_s3 <= hit_s2.status;
			if (hit_s2.status == ST_FOUND) begin
				lcn_s3      <= hit_s2.lcn_base + hit_s2.into;
				clusters_s3 <= clusters;
			end else begin
				lcn_s3      <= '0;
				clusters_s3 <= '0;
			end
		end
	end

	// Stage 4: scale clusters to sectors
	assign start_prod = lcn_s3 * spc_q;
	assign count_prod = clusters_s3 * spc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (s4_free) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_free) begin
			status_s4 <= status_s3;
			start_s4  <= start_prod[63:0];
			count_s4  <= count_prod[38:0];
		end
	end

	assign result_valid = valid_s4;
	assign status       = status_s4;
	assign start_sector = start_s4;
	assign sector_count = count_s4;

endmodule

// ===== rtl/rvts_parse.sv =====
// Runlist byte parser: holds lookup state and decides hit, end or malformed per byte.
module rvts_parse
	import rvts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        action,
	input  logic [63:0] target_vcn,
	input  logic [31:0] cluster_count,
	input  logic [7:0]  runlist_byte,
	output run_hit_t    hit
);

	phase_t      phase_q, phase_d;
	logic [3:0]  len_bytes_q;
	logic [3:0]  off_bytes_q;
	logic [2:0]  byte_idx_q;
	logic [63:0] run_len_q;
	logic [63:0] run_delta_q;
	logic [63:0] vcn_acc_q;
	logic [63:0] lcn_acc_q;
	logic [63:0] sought_q;
	logic [31:0] wanted_q;

	logic [63:0] shifted;
	logic [63:0] len_merged;
	logic [63:0] delta_merged;
	logic [3:0]  hdr_len;
	logic [3:0]  hdr_off;
	logic        hdr_zero;
	logic        hdr_bad;
	logic        last_len;
	logic        last_off;
	logic [63:0] fin_len;
	logic [63:0] fin_delta;
	logic [63:0] into;
	logic        in_run;
	logic [63:0] vcn_next;
	logic [63:0] lcn_next;
	logic        passed;
	logic        finishing;
	phase_t      finish_phase;

	// Sign-extend a run offset of 1..7 bytes; 0 and 8 bytes stay as read
	function automatic logic [63:0] sext_delta(input logic [63:0] raw, input logic [3:0] nbytes);
		logic [63:0] r;
		r = raw;
		for (int k = 1; k < int'(MAX_FIELD_BYTES); k++) begin
			if (nbytes == 4'(k) && raw[8*k-1]) begin
				r = r | ({64{1'b1}} << (8*k));
			end
		end
		return r;
	endfunction

	// Merge the incoming byte and evaluate the run end
	always_comb begin
		shifted      = {56'd0, runlist_byte} << {byte_idx_q, 3'b000};
		len_merged   = run_len_q | shifted;
		delta_merged = run_delta_q | shifted;
		hdr_len      = runlist_byte[3:0];
		hdr_off      = runlist_byte[7:4];
		hdr_zero     = (runlist_byte == 8'd0);
		hdr_bad      = (hdr_len > MAX_FIELD_BYTES) || (hdr_off > MAX_FIELD_BYTES);
		last_len     = (({1'b0, byte_idx_q} + 4'd1) >= len_bytes_q);
		last_off     = (({1'b0, byte_idx_q} + 4'd1) >= off_bytes_q);

		case (phase_q)
			PH_LENGTH: begin
				fin_len   = len_merged;
				fin_delta = run_delta_q;
			end
			PH_OFFSET: begin
				fin_len   = run_len_q;
				fin_delta = delta_merged;
			end
			default: begin
				fin_len   = '0;
				fin_delta = '0;
			end
		endcase

		into     = sought_q - vcn_acc_q;
		in_run   = (vcn_acc_q <= sought_q) && (into < fin_len);
		vcn_next = vcn_acc_q + fin_len;
		lcn_next = lcn_acc_q + sext_delta(fin_delta, off_bytes_q);
		passed   = (vcn_next > sought_q);

		case (phase_q)
			PH_HEADER: finishing = !hdr_zero && !hdr_bad && hdr_len == 4'd0 && hdr_off == 4'd0;
			PH_LENGTH: finishing = last_len && off_bytes_q == 4'd0;
			PH_OFFSET: finishing = last_off;
			default:   finishing = 1'b0;
		endcase

		finish_phase = (in_run || passed) ? PH_DONE : PH_HEADER;
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (action == ACT_BEGIN) begin
			phase_d = PH_HEADER;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_zero || hdr_bad) begin
						phase_d = PH_DONE;
					end else if (hdr_len != 4'd0) begin
						phase_d = PH_LENGTH;
					end else if (hdr_off != 4'd0) begin
						phase_d = PH_OFFSET;
					end else begin
						phase_d = finish_phase;
					end
				end
				PH_LENGTH: begin
					if (last_len) begin
						phase_d = (off_bytes_q != 4'd0) ? PH_OFFSET : finish_phase;
					end
				end
				PH_OFFSET: begin
					if (last_off) begin
						phase_d = finish_phase;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// Result record for this byte
	always_comb begin
		hit.emit     = 1'b0;
		hit.status   = ST_END;
		hit.into     = into;
		hit.run_len  = fin_len;
		hit.lcn_base = lcn_acc_q + sext_delta(fin_delta, off_bytes_q);
		hit.wanted   = wanted_q;
		if (step && action == ACT_BYTE) begin
			if (phase_q == PH_HEADER && hdr_zero) begin
				hit.emit   = 1'b1;
				hit.status = ST_END;
			end else if (phase_q == PH_HEADER && hdr_bad) begin
				hit.emit   = 1'b1;
				hit.status = ST_MALFORMED;
			end else if (finishing && (in_run || passed)) begin
				hit.emit   = 1'b1;
				hit.status = in_run ? ST_FOUND : ST_END;
			end
		end
	end

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (step) begin
			phase_q <= phase_d;
		end
	end

	// Lookup state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_bytes_q <= '0;
			off_bytes_q <= '0;
			byte_idx_q  <= '0;
			run_len_q   <= '0;
			run_delta_q <= '0;
			vcn_acc_q   <= '0;
			lcn_acc_q   <= '0;
			sought_q    <= '0;
			wanted_q    <= '0;
		end else if (step) begin
			if (action == ACT_BEGIN) begin
				sought_q  <= target_vcn;
				wanted_q  <= cluster_count;
				vcn_acc_q <= '0;
				lcn_acc_q <= '0;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (!hdr_zero) begin
							len_bytes_q <= hdr_len;
							off_bytes_q <= hdr_off;
							if (!hdr_bad) begin
								byte_idx_q  <= '0;
								run_len_q   <= '0;
								run_delta_q <= '0;
							end
						end
					end
					PH_LENGTH: begin
						run_len_q  <= len_merged;
						byte_idx_q <= last_len ? 3'd0 : byte_idx_q + 3'd1;
					end
					PH_OFFSET: begin
						run_delta_q <= delta_merged;
						byte_idx_q  <= last_off ? 3'd0 : byte_idx_q + 3'd1;
					end
					default: begin
					end
				endcase
				// Advance past a run that misses the target
				if (finishing && !in_run) begin
					vcn_acc_q <= vcn_next;
					lcn_acc_q <= lcn_next;
				end
			end
		end
	end

endmodule

// ===== rtl/rvts_checker.sv =====
// Port-level assertions for the runlist decoder, bound to the top level.
`include "runlist_vcn_to_sector_defines.svh"

module rvts_checker
	import rvts_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  status,
	input logic [63:0] start_sector,
	input logic [38:0] sector_count
);

	// A stalled result holds its payload
	`RVTS_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(status) && $stable(start_sector) && $stable(sector_count), "stalled result changed")

	// End and malformed results carry no sector range
	`RVTS_ASSERT_IMP(a_miss_zero, clk, arst_n, result_valid && status != ST_FOUND, start_sector == 64'd0 && sector_count == 39'd0, "miss result has nonzero fields")

	// With the output register empty nothing upstream can stall
	`RVTS_ASSERT_IMP(a_ready_when_drained, clk, arst_n, !result_valid, item_ready, "input stalled with empty output")

	// Status never takes the unused code
	`RVTS_ASSERT_IMP(a_status_code, clk, arst_n, result_valid, status == ST_FOUND || status == ST_END || status == ST_MALFORMED, "unused status code")

endmodule

bind runlist_vcn_to_sector rvts_checker u_rvts_checker (.*);

// ===== tb/tb_runlist_vcn_to_sector.sv =====
// Self-checking testbench for runlist_vcn_to_sector: random runlists through a per-item predictor.
module tb_runlist_vcn_to_sector;
	import rvts_pkg::*;

	typedef struct {
		logic        act;
		logic [63:0] vcn;
		logic [31:0] count;
		logic [7:0]  data;
	} runlist_item_t;

	typedef struct {
		logic [1:0]  status;
		logic [63:0] first_sector;
		logic [38:0] sectors;
	} sector_map_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        action = ACT_BEGIN;
	logic [63:0] target_vcn = 64'd0;
	logic [31:0] cluster_count = 32'd0;
	logic [7:0]  runlist_byte = 8'd0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  status;
	logic [63:0] start_sector;
	logic [38:0] sector_count;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	runlist_vcn_to_sector DUT (.*);

	// Pending runlist items and the sector maps they must produce
	runlist_item_t pending_items[$];
	sector_map_t   expected_maps[$];
	int            fault_count = 0;

	// Handshake bookkeeping between the edge processes
	bit in_xfer = 1'b0;
	bit out_xfer = 1'b0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	int in_gap = 0;
	int out_wait = 0;

	// Decoder state mirrored by the predictor
	logic [7:0]  spc = SPC_RESET;
	phase_t      dec_phase = PH_IDLE;
	logic [3:0]  len_bytes = 4'd0;
	logic [3:0]  off_bytes = 4'd0;
	logic [2:0]  byte_idx = 3'd0;
	logic [63:0] run_len = 64'd0;
	logic [63:0] run_dlt = 64'd0;
	logic [63:0] vcn_acc = 64'd0;
	logic [63:0] lcn_acc = 64'd0;
	logic [63:0] sought = 64'd0;
	logic [31:0] wanted = 32'd0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Record a sector map and finish the lookup
	task automatic post_map(input logic [1:0] st, input logic [63:0] sec,
			input logic [38:0] cnt);
		sector_map_t m;
		m.status = st;
		m.first_sector = sec;
		m.sectors = cnt;
		expected_maps.push_back(m);
		dec_phase = PH_DONE;
	endtask

	// Close one run: map the sought VCN if it falls inside, else advance
	task automatic close_run();
		logic [63:0] delta, into, remaining, clusters, lcn, prod;
		int nbits;
		delta = run_dlt;
		nbits = 8 * off_bytes;
		if (off_bytes != 4'd0 && off_bytes < MAX_FIELD_BYTES) begin
			if (run_dlt[nbits - 1])
				delta = delta | ({64{1'b1}} << nbits);
		end
		if (vcn_acc <= sought && (sought - vcn_acc) < run_len) begin
			into = sought - vcn_acc;
			remaining = run_len - into;
			clusters = ({32'd0, wanted} < remaining) ? {32'd0, wanted} : remaining;
			lcn = lcn_acc + delta + into;
			prod = clusters * {56'd0, spc};
			post_map(ST_FOUND, lcn * {56'd0, spc}, prod[38:0]);
		end else begin
			vcn_acc = vcn_acc + run_len;
			lcn_acc = lcn_acc + delta;
			if (vcn_acc > sought)
				post_map(ST_END, 64'd0, 39'd0);
			else
				dec_phase = PH_HEADER;
		end
	endtask

	// Advance the decoder by one accepted item
	task automatic advance_decoder(input runlist_item_t it);
		if (it.act == ACT_BEGIN) begin
			sought = it.vcn;
			wanted = it.count;
			vcn_acc = 64'd0;
			lcn_acc = 64'd0;
			dec_phase = PH_HEADER;
		end else begin
			case (dec_phase)
				PH_HEADER: begin
					if (it.data == 8'd0) begin
						post_map(ST_END, 64'd0, 39'd0);
					end else begin
						len_bytes = it.data[3:0];
						off_bytes = it.data[7:4];
						if (len_bytes > MAX_FIELD_BYTES || off_bytes > MAX_FIELD_BYTES) begin
							post_map(ST_MALFORMED, 64'd0, 39'd0);
						end else begin
							byte_idx = 3'd0;
							run_len = 64'd0;
							run_dlt = 64'd0;
							dec_phase = (len_bytes != 4'd0) ? PH_LENGTH : PH_OFFSET;
						end
					end
				end
				PH_LENGTH: begin
					run_len = run_len | ({56'd0, it.data} << (8 * byte_idx));
					if ({1'b0, byte_idx} + 4'd1 >= len_bytes) begin
						byte_idx = 3'd0;
						if (off_bytes != 4'd0)
							dec_phase = PH_OFFSET;
						else
							close_run();
					end else begin
						byte_idx = byte_idx + 3'd1;
					end
				end
				PH_OFFSET: begin
					run_dlt = run_dlt | ({56'd0, it.data} << (8 * byte_idx));
					if ({1'b0, byte_idx} + 4'd1 >= off_bytes) begin
						byte_idx = 3'd0;
						close_run();
					end else begin
						byte_idx = byte_idx + 3'd1;
					end
				end
				default: ;
			endcase
		end
	endtask

	// Compare one transferred result against the oldest sector map
	task automatic check_map();
		sector_map_t want_map;
		if (expected_maps.size() == 0) begin
			$display("%0t: unexpected result status %0d sector %h count %h", $time,
				status, start_sector, sector_count);
			fault_count++;
		end else begin
			want_map = expected_maps.pop_front();
			if (status !== want_map.status) begin
				$display("%0t: status expected %0d, got %0d", $time, want_map.status, status);
				fault_count++;
			end
			if (start_sector !== want_map.first_sector) begin
				$display("%0t: start_sector expected %h, got %h", $time,
					want_map.first_sector, start_sector);
				fault_count++;
			end
			if (sector_count !== want_map.sectors) begin
				$display("%0t: sector_count expected %h, got %h", $time,
					want_map.sectors, sector_count);
				fault_count++;
			end
		end
	endtask

	task automatic queue_begin(input logic [63:0] vcn, input logic [31:0] cnt);
		runlist_item_t it;
		it.act = ACT_BEGIN;
		it.vcn = vcn;
		it.count = cnt;
		it.data = 8'($urandom);
		pending_items.push_back(it);
	endtask

	task automatic queue_byte(input logic [7:0] b);
		runlist_item_t it;
		it.act = ACT_BYTE;
		it.vcn = rand64();
		it.count = $urandom;
		it.data = b;
		pending_items.push_back(it);
	endtask

	// Fill the queue with lookups: mostly well-formed runlists, some broken ones
	task automatic queue_lookups(input int quota);
		logic [7:0]  run_bytes[$];
		logic [63:0] lens[$];
		logic [63:0] starts[$];
		logic [63:0] acc, len, vcn;
		logic [31:0] cnt;
		logic [7:0]  b;
		int counted, kind, nruns, lb, ob, k, pick;
		counted = 0;
		while (counted < quota) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				run_bytes.delete();
				lens.delete();
				starts.delete();
				acc = 64'd0;
				nruns = $urandom_range(1, 6);
				for (int r = 0; r < nruns; r++) begin
					lb = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 3) : $urandom_range(0, 8);
					ob = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 8);
					if (lb == 0 && ob == 0)
						lb = 1;
					run_bytes.push_back({ob[3:0], lb[3:0]});
					len = 64'd0;
					for (int i = 0; i < lb; i++) begin
						b = 8'($urandom);
						len = len | ({56'd0, b} << (8 * i));
						run_bytes.push_back(b);
					end
					for (int i = 0; i < ob; i++)
						run_bytes.push_back(8'($urandom));
					starts.push_back(acc);
					lens.push_back(len);
					acc = acc + len;
				end
				// aim mostly inside a run, else past the end or anywhere
				pick = $urandom_range(0, nruns - 1);
				if ($urandom_range(0, 3) != 0 && lens[pick] != 64'd0)
					vcn = starts[pick] + (rand64() % lens[pick]);
				else if ($urandom_range(0, 1) == 0)
					vcn = acc + $urandom_range(0, 3);
				else
					vcn = rand64();
				cnt = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 40);
				queue_begin(vcn, cnt);
				counted++;
				// cut some lists short so the next begin restarts mid-run
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, run_bytes.size())
					: run_bytes.size();
				for (int i = 0; i < k; i++)
					queue_byte(run_bytes[i]);
				counted += k;
				if (k == run_bytes.size()) begin
					queue_byte(8'h00);
					counted++;
				end
			end else if (kind <= 8) begin
				// random bytes after a begin, mostly bad headers
				queue_begin(rand64(), $urandom);
				k = $urandom_range(1, 10);
				for (int i = 0; i < k; i++)
					queue_byte(8'($urandom));
				counted += k + 1;
			end else begin
				// stray bytes, usually ignored
				k = $urandom_range(1, 4);
				for (int i = 0; i < k; i++)
					queue_byte(8'($urandom));
			end
		end
	endtask

	// Hold until every item is sent and every result is in, then let the pipe drain
	task automatic wait_drained();
		@(posedge clk);
		while (pending_items.size() != 0 || item_valid || expected_maps.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the cluster size register over APB and read it back
	task automatic set_cluster_sectors(input logic [7:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_SPC, 2'b00};
		pwdata <= {24'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		spc = v;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== v) begin
			$display("%0t: cluster size readback expected %h, got %h", $time,
				v, prdata[7:0]);
			fault_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Sample transfers on both channels
	always @(posedge clk) begin : sample_transfers
		runlist_item_t it;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				in_xfer = 1'b1;
				it.act = action;
				it.vcn = target_vcn;
				it.count = cluster_count;
				it.data = runlist_byte;
				advance_decoder(it);
			end
			if (result_valid && result_ready) begin
				out_xfer = 1'b1;
				check_map();
			end
		end
	end

	// Present items, with a random gap before each one
	always @(negedge clk) begin : drive_items
		runlist_item_t nxt;
		logic nv;
		nv = item_valid;
		if (in_xfer) begin
			in_xfer = 1'b0;
			nv = 1'b0;
			if ($urandom_range(0, 15) == 0)
				in_calm = !in_calm;
			in_gap = in_calm ? 0 : $urandom_range(0, 19);
		end
		if (!nv && arst_n) begin
			if (in_gap > 0) begin
				in_gap--;
			end else if (pending_items.size() > 0) begin
				nxt = pending_items.pop_front();
				action <= nxt.act;
				target_vcn <= nxt.vcn;
				cluster_count <= nxt.count;
				runlist_byte <= nxt.data;
				nv = 1'b1;
			end
		end
		item_valid <= nv;
	end

	// Stall the result channel for a random count after each transfer
	always @(negedge clk) begin : drive_ready
		if (out_xfer) begin
			out_xfer = 1'b0;
			if ($urandom_range(0, 15) == 0)
				out_calm = !out_calm;
			out_wait = out_calm ? 0 : $urandom_range(0, 19);
		end
		if (out_wait > 0) begin
			out_wait--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	initial begin : run_timeout
		#3000000;
		$display("tb_runlist_vcn_to_sector NOT OK");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] settings[$];
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed lookups at the reset cluster size
		queue_byte(8'h11);
		queue_begin(64'd0, 32'hFFFF_FFFF);
		queue_byte(8'h11);
		queue_byte(8'h05);
		queue_byte(8'h10);
		queue_byte(8'hFF);
		queue_begin(64'd5, 32'd1);
		queue_byte(8'h00);
		queue_begin(64'd3, 32'd2);
		queue_byte(8'h91);
		queue_begin(64'd3, 32'd2);
		queue_byte(8'h19);
		queue_begin(64'd10, 32'd3);
		queue_byte(8'h01);
		queue_byte(8'h04);
		queue_byte(8'h10);
		queue_byte(8'h80);
		queue_byte(8'h11);
		queue_byte(8'h10);
		queue_byte(8'hFF);
		queue_begin({64{1'b1}}, 32'd0);
		queue_byte(8'h01);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		wait_drained();

		// Random lookups under several cluster sizes, extremes included
		settings = '{8'd1, 8'd128, 8'd255, 8'd0, 8'd8};
		settings.push_back($urandom_range(2, 127));
		foreach (settings[i]) begin
			set_cluster_sectors(settings[i]);
			@(posedge clk);
			queue_lookups(130);
			wait_drained();
		end

		if (fault_count == 0)
			$display("tb_runlist_vcn_to_sector OK");
		else
			$display("tb_runlist_vcn_to_sector NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rvts_pkg.sv
rtl/rvts_parse.sv
rtl/runlist_vcn_to_sector.sv
rtl/rvts_checker.sv
tb/tb_runlist_vcn_to_sector.sv
